/* design/m6805_pkg.sv */
// ----------------------------------------------------------------------------
// m6805_pkg
// Shared types and constants for the 6805 execute and flag unit: operation
// codes, condition code bit positions and the request/result records.
// ----------------------------------------------------------------------------
package m6805_pkg;

  // operation codes, mnemonics in alphabetical order
  typedef enum logic [5:0] {
    OP_ADC   = 6'd0,  OP_ADD   = 6'd1,  OP_AND   = 6'd2,  OP_ASL   = 6'd3,
    OP_ASR   = 6'd4,  OP_BCC   = 6'd5,  OP_BCLR  = 6'd6,  OP_BCS   = 6'd7,
    OP_BEQ   = 6'd8,  OP_BHCC  = 6'd9,  OP_BHCS  = 6'd10, OP_BHI   = 6'd11,
    OP_BIH   = 6'd12, OP_BIL   = 6'd13, OP_BIT   = 6'd14, OP_BLS   = 6'd15,
    OP_BMC   = 6'd16, OP_BMI   = 6'd17, OP_BMS   = 6'd18, OP_BNE   = 6'd19,
    OP_BPL   = 6'd20, OP_BRA   = 6'd21, OP_BRCLR = 6'd22, OP_BRN   = 6'd23,
    OP_BRSET = 6'd24, OP_BSET  = 6'd25, OP_CLC   = 6'd26, OP_CLI   = 6'd27,
    OP_CLR   = 6'd28, OP_CMP   = 6'd29, OP_COM   = 6'd30, OP_CPX   = 6'd31,
    OP_DEC   = 6'd32, OP_EOR   = 6'd33, OP_INC   = 6'd34, OP_JMP   = 6'd35,
    OP_LDA   = 6'd36, OP_LDX   = 6'd37, OP_LSR   = 6'd38, OP_MUL   = 6'd39,
    OP_NEG   = 6'd40, OP_NOP   = 6'd41, OP_ORA   = 6'd42, OP_ROL   = 6'd43,
    OP_ROR   = 6'd44, OP_SBC   = 6'd45, OP_SEC   = 6'd46, OP_SEI   = 6'd47,
    OP_STA   = 6'd48, OP_STOP  = 6'd49, OP_STX   = 6'd50, OP_SUB   = 6'd51,
    OP_TAX   = 6'd52, OP_TST   = 6'd53, OP_TXA   = 6'd54, OP_WAIT  = 6'd55
  } op_t;

  // condition code bit positions
  localparam int unsigned CC_H_BIT = 4;
  localparam int unsigned CC_I_BIT = 3;
  localparam int unsigned CC_N_BIT = 2;
  localparam int unsigned CC_Z_BIT = 1;
  localparam int unsigned CC_C_BIT = 0;

  localparam logic [7:0] CC_RESET = 8'hE8;  // top bits and interrupt mask
  localparam logic [2:0] CC_TOP   = 3'b111; // bits 7..5 read as one

  // one request into the unit
  typedef struct packed {
    op_t        command;
    logic [7:0] operand;
    logic [2:0] bit_number;
    logic       irq_line;
  } req_t;

  // one result out of the unit
  typedef struct packed {
    logic [7:0] mem_result;
    logic       write_back;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] index_out;
    logic [7:0] ccr_out;
    logic       stop_mark;
    logic       wait_mark;
  } res_t;

  // architectural state seen from outside the execute stage
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] idx;
    logic [7:0] ccr;
    logic       stopped;
    logic       waiting;
  } arch_t;

endpackage

/* design/m6805_alu_flag_unit.sv */
// ----------------------------------------------------------------------------
// m6805_alu_flag_unit
// Execute unit of a 6805 core: ALU, condition codes and stop/wait marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: an operation code,
//   the operand byte, a bit number and the IRQ pin level. Result channel
//   (out_valid/out_ready) returns one result per request: write-back byte
//   and flag, branch decision, accumulator, index, condition codes and the
//   stop/wait marks, all as they stand after the operation.
//   Path: a request accepted into the input register is executed from there
//   and its result is offered from the result register, which loads it as
//   soon as that register is free.
//   Throughput: one request per cycle while out_ready is high; the execute
//   pass (8-bit adder, subtractor, shifts, 8x8 multiplier) fits between the
//   two registers; architectural registers update as each result is loaded.
//   Stall: when out_ready is low the result register holds, the request in
//   the input register waits, and in_ready drops once both are occupied.
//   Reset: synchronous, active low; both registers empty, accumulator and
//   index cleared, condition codes 0xE8 (interrupt mask set), marks cleared.
// ----------------------------------------------------------------------------
module m6805_alu_flag_unit
  import m6805_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_command,
  input  logic [7:0] in_operand,
  input  logic [2:0] in_bit_number,
  input  logic       in_irq_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_mem_result,
  output logic       out_write_back,
  output logic       out_branch_taken,
  output logic [7:0] out_acc_out,
  output logic [7:0] out_index_out,
  output logic [7:0] out_ccr_out,
  output logic       out_stop_mark,
  output logic       out_wait_mark
);

  req_t  in_req;
  req_t  req;
  logic  req_valid;
  logic  can_load;
  logic  fire;
  res_t  res;
  res_t  out_res;
  arch_t arch;

  assign in_req = '{command: op_t'(in_command), operand: in_operand,
                    bit_number: in_bit_number, irq_line: in_irq_line};

  // request moves to the result register when that one is free
  assign fire = req_valid && can_load;

  m6805_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .advance   (can_load),
    .req_valid (req_valid),
    .req       (req)
  );

  m6805_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .res   (res),
    .arch  (arch)
  );

  m6805_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_mem_result   = out_res.mem_result;
  assign out_write_back   = out_res.write_back;
  assign out_branch_taken = out_res.branch_taken;
  assign out_acc_out      = out_res.acc_out;
  assign out_index_out    = out_res.index_out;
  assign out_ccr_out      = out_res.ccr_out;
  assign out_stop_mark    = out_res.stop_mark;
  assign out_wait_mark    = out_res.wait_mark;

  // condition code top bits always read as one
  a_ccr_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ccr_out[7:5] == CC_TOP))
    else $error("ccr top bits not set");

  // no write-back means a zero result byte
  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_back) |-> (out_mem_result == 8'h00))
    else $error("result byte without write-back");

  // stop and wait marks stay set until reset
  a_marks_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (arch.stopped || arch.waiting) |=>
      (arch.stopped || !$past(arch.stopped)) && (arch.waiting || !$past(arch.waiting)))
    else $error("stop or wait mark cleared");

  // both stages full and stalled: no new request taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while full");

endmodule

/* design/m6805_in_reg.sv */
// ----------------------------------------------------------------------------
// m6805_in_reg
// Input register: captures one request and holds it until the execute stage
// moves it on.
// ----------------------------------------------------------------------------
module m6805_in_reg
  import m6805_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_req,
  input  logic       advance,
  output logic       req_valid,
  output req_t       req
);

  logic valid_r;
  logic valid_nxt;
  req_t req_r;

  // take a new request when empty or when the held one moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

/* design/m6805_exec.sv */
// ----------------------------------------------------------------------------
// m6805_exec
// Execute stage: accumulator, index, condition code and stop/wait registers,
// plus the single-pass ALU that computes the result and next state.
// ----------------------------------------------------------------------------
module m6805_exec
  import m6805_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  req_t  req,
  output res_t  res,
  output arch_t arch
);

  logic [7:0] acc_r, acc_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] cc_r, cc_nxt;
  logic       stopped_r, stopped_nxt;
  logic       waiting_r, waiting_nxt;

  logic [7:0]  m;
  logic [7:0]  bmask;
  logic        cf;
  logic        add_cin;
  logic [7:0]  add_r;
  logic        add_h;
  logic        add_c;
  logic [7:0]  sub_a;
  logic        sub_bin;
  logic [7:0]  sub_r;
  logic        sub_c;
  logic [15:0] mul_r;
  logic        f_h, f_i, f_n, f_z, f_c;
  logic [7:0]  res_b;
  logic        wb;
  logic        br;

  assign m     = req.operand;
  assign bmask = 8'h01 << req.bit_number;
  assign cf    = cc_r[CC_C_BIT];

  // adder with half carry
  assign add_cin = (req.command == OP_ADC) ? cf : 1'b0;
  assign add_r   = acc_r + m + {7'd0, add_cin};
  assign add_h   = (acc_r[3] & m[3]) | (m[3] & ~add_r[3]) | (~add_r[3] & acc_r[3]);
  assign add_c   = (acc_r[7] & m[7]) | (m[7] & ~add_r[7]) | (~add_r[7] & acc_r[7]);

  // subtractor shared by compare, subtract and index compare
  assign sub_a   = (req.command == OP_CPX) ? idx_r : acc_r;
  assign sub_bin = (req.command == OP_SBC) ? cf : 1'b0;
  assign sub_r   = sub_a - m - {7'd0, sub_bin};
  assign sub_c   = (~sub_a[7] & m[7]) | (m[7] & sub_r[7]) | (sub_r[7] & ~sub_a[7]);

  // 8x8 multiply
  assign mul_r = idx_r * acc_r;

  // operation decode
  always_comb begin
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;
    stopped_nxt = stopped_r;
    waiting_nxt = waiting_r;
    f_h   = cc_r[CC_H_BIT];
    f_i   = cc_r[CC_I_BIT];
    f_n   = cc_r[CC_N_BIT];
    f_z   = cc_r[CC_Z_BIT];
    f_c   = cc_r[CC_C_BIT];
    res_b = 8'h00;
    wb    = 1'b0;
    br    = 1'b0;
    case (req.command)
      OP_ADC, OP_ADD: begin
        acc_nxt = add_r;
        f_h = add_h;
        f_n = add_r[7];
        f_z = (add_r == 8'h00);
        f_c = add_c;
      end
      OP_AND: begin
        acc_nxt = acc_r & m;
        f_n = acc_nxt[7];
        f_z = (acc_nxt == 8'h00);
      end
      OP_ASL: begin
        res_b = {m[6:0], 1'b0};
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        f_c = m[7];
        wb  = 1'b1;
      end
      OP_ASR: begin
        res_b = {m[7], m[7:1]};
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        f_c = m[0];
        wb  = 1'b1;
      end
      OP_BCC:  br = !cf;
      OP_BCLR: begin
        res_b = m & ~bmask;
        wb    = 1'b1;
      end
      OP_BCS:  br = cf;
      OP_BEQ:  br = cc_r[CC_Z_BIT];
      OP_BHCC: br = !cc_r[CC_H_BIT];
      OP_BHCS: br = cc_r[CC_H_BIT];
      OP_BHI:  br = !cf && !cc_r[CC_Z_BIT];
      OP_BIH:  br = req.irq_line;
      OP_BIL:  br = !req.irq_line;
      OP_BIT: begin
        f_n = acc_r[7] & m[7];
        f_z = ((acc_r & m) == 8'h00);
      end
      OP_BLS:  br = cf || cc_r[CC_Z_BIT];
      OP_BMC:  br = !cc_r[CC_I_BIT];
      OP_BMI:  br = cc_r[CC_N_BIT];
      OP_BMS:  br = cc_r[CC_I_BIT];
      OP_BNE:  br = !cc_r[CC_Z_BIT];
      OP_BPL:  br = !cc_r[CC_N_BIT];
      OP_BRA, OP_JMP: br = 1'b1;
      OP_BRCLR: begin
        f_c = |(m & bmask);
        br  = !f_c;
      end
      OP_BRN:  br = 1'b0;
      OP_BRSET: begin
        f_c = |(m & bmask);
        br  = f_c;
      end
      OP_BSET: begin
        res_b = m | bmask;
        wb    = 1'b1;
      end
      OP_CLC:  f_c = 1'b0;
      OP_CLI:  f_i = 1'b0;
      OP_CLR: begin
        f_n = 1'b0;
        f_z = 1'b1;
        wb  = 1'b1;
      end
      OP_CMP, OP_CPX: begin
        f_n = sub_r[7];
        f_z = (sub_r == 8'h00);
        f_c = sub_c;
      end
      OP_COM: begin
        res_b = ~m;
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        f_c = 1'b1;
        wb  = 1'b1;
      end
      OP_DEC: begin
        res_b = m - 8'd1;
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        wb  = 1'b1;
      end
      OP_EOR: begin
        acc_nxt = acc_r ^ m;
        f_n = acc_nxt[7];
        f_z = (acc_nxt == 8'h00);
      end
      OP_INC: begin
        res_b = m + 8'd1;
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        wb  = 1'b1;
      end
      OP_LDA: begin
        acc_nxt = m;
        f_n = m[7];
        f_z = (m == 8'h00);
      end
      OP_LDX: begin
        idx_nxt = m;
        f_n = m[7];
        f_z = (m == 8'h00);
      end
      OP_LSR: begin
        res_b = {1'b0, m[7:1]};
        f_n = 1'b0;
        f_z = (res_b == 8'h00);
        f_c = m[0];
        wb  = 1'b1;
      end
      OP_MUL: begin
        idx_nxt = mul_r[15:8];
        acc_nxt = mul_r[7:0];
        f_h = 1'b0;
        f_c = 1'b0;
      end
      OP_NEG: begin
        res_b = 8'h00 - m;
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        f_c = (res_b != 8'h00);
        wb  = 1'b1;
      end
      OP_NOP: begin
      end
      OP_ORA: begin
        acc_nxt = acc_r | m;
        f_n = acc_nxt[7];
        f_z = (acc_nxt == 8'h00);
      end
      OP_ROL: begin
        res_b = {m[6:0], cf};
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        f_c = m[7];
        wb  = 1'b1;
      end
      OP_ROR: begin
        res_b = {cf, m[7:1]};
        f_n = res_b[7];
        f_z = (res_b == 8'h00);
        f_c = m[0];
        wb  = 1'b1;
      end
      OP_SBC, OP_SUB: begin
        acc_nxt = sub_r;
        f_n = sub_r[7];
        f_z = (sub_r == 8'h00);
        f_c = sub_c;
      end
      OP_SEC:  f_c = 1'b1;
      OP_SEI:  f_i = 1'b1;
      OP_STA: begin
        res_b = acc_r;
        f_n = acc_r[7];
        f_z = (acc_r == 8'h00);
        wb  = 1'b1;
      end
      OP_STOP: begin
        f_i = 1'b0;
        stopped_nxt = 1'b1;
      end
      OP_STX: begin
        res_b = idx_r;
        f_n = idx_r[7];
        f_z = (idx_r == 8'h00);
        wb  = 1'b1;
      end
      OP_TAX:  idx_nxt = acc_r;
      OP_TST: begin
        f_n = m[7];
        f_z = (m == 8'h00);
      end
      OP_TXA:  acc_nxt = idx_r;
      OP_WAIT: begin
        f_i = 1'b0;
        waiting_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    cc_nxt = {CC_TOP, f_h, f_i, f_n, f_z, f_c};
  end

  // architectural registers, updated as a request leaves for the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= 8'h00;
      idx_r     <= 8'h00;
      cc_r      <= CC_RESET;
      stopped_r <= 1'b0;
      waiting_r <= 1'b0;
    end else if (fire) begin
      acc_r     <= acc_nxt;
      idx_r     <= idx_nxt;
      cc_r      <= cc_nxt;
      stopped_r <= stopped_nxt;
      waiting_r <= waiting_nxt;
    end
  end

  // result record
  always_comb begin
    res.mem_result   = res_b;
    res.write_back   = wb;
    res.branch_taken = br;
    res.acc_out      = acc_nxt;
    res.index_out    = idx_nxt;
    res.ccr_out      = cc_nxt;
    res.stop_mark    = stopped_nxt;
    res.wait_mark    = waiting_nxt;
  end

  assign arch = '{acc: acc_r, idx: idx_r, ccr: cc_r, stopped: stopped_r, waiting: waiting_r};

endmodule

/* design/m6805_out_reg.sv */
// ----------------------------------------------------------------------------
// m6805_out_reg
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module m6805_out_reg
  import m6805_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // free when empty or when the held result is taken this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
